[rtl/core/counting_semaphore_table_top_macros.svh]
// Assertion macros shared by the semaphore table RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef COUNTING_SEMAPHORE_TABLE_TOP_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CSEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/csem_pkg.sv]
// Shared types and constants for the counting semaphore table.
// No dependencies.
`timescale 1ns / 1ps

package csem_pkg;

    // fixed beat field widths
    localparam int CMD_W    = 2;
    localparam int IDX_FW   = 7;
    localparam int COUNT_FW = 16;
    localparam int STATUS_W = 2;

    // free-slot search works on groups of this many slots
    localparam int GRP_SIZE = 16;
    localparam int GRP_BITS = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_WAIT   = 2'd1,
        CMD_SIGNAL = 2'd2,
        CMD_FREE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_ALLOC = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND_GROUP,
        S_FIND_SLOT,
        S_EXEC
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // beat accepted, latch fields, read count
        logic find_group;  // pick lowest group with a free slot
        logic find_slot;   // pick slot in group, allocate it
        logic exec;        // wait / signal / free update
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic table_full;
    } sts_t;

endpackage

[rtl/core/counting_semaphore_table_top.sv]
// Top level of the counting semaphore table.
// Instantiates csem_ctrl and csem_dpath; uses csem_pkg.
`timescale 1ns / 1ps

// Counting semaphore table, one command per beat, one result per command.
// A beat is taken on the clock edge where start is high and busy is low.
// Every command answers with exactly one result beat: done is high for one
// cycle with status, slot_out, must_block, wake_one and count_after valid.
// There is no back-pressure on the result side, so the receiver must take
// done as it comes.
//
// Steps per command:
//   wait / signal / free : count read on the accept edge, then a
//                          read-modify-write on the count memory.
//   create               : accept, group search over 16-slot groups,
//                          then slot pick and count write.
//   create on full table : accept, then group search, which answers full.
// done rises in the cycle after the last busy cycle; busy is already low
// then, so the next command may be accepted alongside that result.
//
// Behaviour notes:
//   - create takes the lowest free slot and stores initial_count saturated
//     to the COUNT_BITS range; target_slot is ignored.
//   - wait decrements (holds at minimum) and flags must_block when the new
//     count is negative; signal increments (holds at maximum) and flags
//     wake_one when the new count is zero or below.
//   - free clears the slot and its count.
//   - any command other than create on an unallocated or out-of-range slot
//     reports slot-not-allocated and changes nothing.
// Allocation bits clear on reset; count entries are only ever read after
// create has written them, so the count memory needs no clearing pass.
module counting_semaphore_table_top #(
    parameter int NUM_SEMAPHORES = 128,
    parameter int COUNT_BITS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  csem_pkg::cmd_t                       command,
    input  logic [csem_pkg::IDX_FW-1:0]          target_slot,
    input  logic signed [csem_pkg::COUNT_FW-1:0] initial_count,
    output logic                                 done,
    output csem_pkg::status_t                    status,
    output logic [csem_pkg::IDX_FW-1:0]          slot_out,
    output logic                                 must_block,
    output logic                                 wake_one,
    output logic signed [csem_pkg::COUNT_FW-1:0] count_after
);

    csem_pkg::ctl_t ctl;
    csem_pkg::sts_t sts;

    // sequencing
    csem_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    // table state, arithmetic and result registers
    csem_dpath #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .command       (command),
        .target_slot   (target_slot),
        .initial_count (initial_count),
        .done          (done),
        .status        (status),
        .slot_out      (slot_out),
        .must_block    (must_block),
        .wake_one      (wake_one),
        .count_after   (count_after)
    );

endmodule

[rtl/core/csem_ctrl.sv]
// Sequencing state machine for the counting semaphore table.
// Depends on csem_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "counting_semaphore_table_top_macros.svh"

module csem_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  csem_pkg::cmd_t    command,
    input  csem_pkg::sts_t    sts,
    output csem_pkg::ctl_t    ctl,
    output logic              busy
);

    csem_pkg::state_t state_reg;
    csem_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csem_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            csem_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
                if (start)
                begin
                    if (command == csem_pkg::CMD_CREATE)
                    begin
                        state_next = csem_pkg::S_FIND_GROUP;
                    end
                    else
                    begin
                        state_next = csem_pkg::S_EXEC;
                    end
                end
            end
            csem_pkg::S_FIND_GROUP:
            begin
                ctl.find_group = 1'b1;
                // full table answers straight away
                state_next = sts.table_full ? csem_pkg::S_IDLE : csem_pkg::S_FIND_SLOT;
            end
            csem_pkg::S_FIND_SLOT:
            begin
                ctl.find_slot = 1'b1;
                state_next    = csem_pkg::S_IDLE;
            end
            csem_pkg::S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = csem_pkg::S_IDLE;
            end
        endcase
    end

    `CSEM_ASSERT_NOW(a_ctl_onehot, 1'b1, $onehot0(ctl), "more than one datapath command")
    `CSEM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `CSEM_ASSERT_NEXT(a_exec_ends, ctl.exec || ctl.find_slot, !busy, "command did not retire")

endmodule

[rtl/core/csem_dpath.sv]
// Datapath of the counting semaphore table: allocation bits, count memory,
// free-slot search, count update and result registers. Uses csem_pkg and macros.
`timescale 1ns / 1ps
`include "counting_semaphore_table_top_macros.svh"

module csem_dpath #(
    parameter int NUM_SEMAPHORES = 128,
    parameter int COUNT_BITS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csem_pkg::ctl_t                      ctl,
    output csem_pkg::sts_t                      sts,
    input  csem_pkg::cmd_t                      command,
    input  logic [csem_pkg::IDX_FW-1:0]         target_slot,
    input  logic signed [csem_pkg::COUNT_FW-1:0] initial_count,
    output logic                                done,
    output csem_pkg::status_t                   status,
    output logic [csem_pkg::IDX_FW-1:0]         slot_out,
    output logic                                must_block,
    output logic                                wake_one,
    output logic signed [csem_pkg::COUNT_FW-1:0] count_after
);

    localparam int IDX_W    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int USED_W   = $clog2(NUM_SEMAPHORES + 1);
    localparam int NUM_GRPS = (NUM_SEMAPHORES + csem_pkg::GRP_SIZE - 1) / csem_pkg::GRP_SIZE;
    localparam int GRP_W    = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
    localparam int PAD_W    = NUM_GRPS * csem_pkg::GRP_SIZE;

    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0]        CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    localparam logic signed [32:0]           WIDE_MAX = 33'(CNT_MAX);
    localparam logic signed [32:0]           WIDE_MIN = 33'(CNT_MIN);

    // latched beat
    csem_pkg::cmd_t                       cmd_reg;
    logic [csem_pkg::IDX_FW-1:0]          idx_reg;
    logic signed [csem_pkg::COUNT_FW-1:0] init_reg;

    // state
    logic [NUM_SEMAPHORES-1:0]            in_use_reg;
    logic [NUM_SEMAPHORES-1:0]            in_use_next;
    logic [USED_W-1:0]                    used_reg;
    logic [USED_W-1:0]                    used_next;
    logic signed [COUNT_BITS-1:0]         count_mem [NUM_SEMAPHORES];
    logic signed [COUNT_BITS-1:0]         rd_count_reg;
    logic [GRP_W-1:0]                     grp_reg;

    // results
    logic                                 done_reg;
    csem_pkg::status_t                    status_reg;
    csem_pkg::status_t                    status_next;
    logic [csem_pkg::IDX_FW-1:0]          slot_reg;
    logic [csem_pkg::IDX_FW-1:0]          slot_next;
    logic                                 block_reg;
    logic                                 block_next;
    logic                                 wake_reg;
    logic                                 wake_next;
    logic signed [csem_pkg::COUNT_FW-1:0] count_reg;
    logic signed [COUNT_BITS-1:0]         upd_count;
    logic                                 res_load;

    // comb
    logic [PAD_W-1:0]                     used_pad;
    logic [NUM_GRPS-1:0]                  grp_free;
    logic [GRP_W-1:0]                     grp_sel;
    logic [csem_pkg::GRP_SIZE-1:0]        grp_bits;
    logic [csem_pkg::GRP_BITS-1:0]        bit_sel;
    logic [GRP_W+csem_pkg::GRP_BITS-1:0]  alloc_wide;
    logic [IDX_W-1:0]                     alloc_slot;
    logic [31:0]                          alloc_w32;
    logic [31:0]                          idx_w32;
    logic [31:0]                          rd_w32;
    logic [IDX_W-1:0]                     idx_slot;
    logic [IDX_W-1:0]                     rd_addr;
    logic                                 in_range;
    logic                                 alloc_ok;
    logic signed [32:0]                   init_w;
    logic signed [32:0]                   sat_w;
    logic signed [COUNT_BITS-1:0]         init_sat;
    logic signed [COUNT_BITS-1:0]         cnt_dec;
    logic signed [COUNT_BITS-1:0]         cnt_inc;
    logic signed [32:0]                   res_wide;
    logic                                 wr_en;
    logic [IDX_W-1:0]                     wr_addr;
    logic signed [COUNT_BITS-1:0]         wr_data;

    assign sts.table_full = (used_reg == USED_W'(NUM_SEMAPHORES));

    // index views
    always_comb
    begin
        idx_w32  = 32'(idx_reg);
        idx_slot = idx_w32[IDX_W-1:0];
        rd_w32   = 32'(target_slot);
        rd_addr  = rd_w32[IDX_W-1:0];
        in_range = (idx_w32 < 32'(NUM_SEMAPHORES));
        alloc_ok = in_range && in_use_reg[idx_slot];
    end

    // lowest free slot: group stage, then slot-in-group stage
    always_comb
    begin
        used_pad                     = '1;
        used_pad[NUM_SEMAPHORES-1:0] = in_use_reg;
        for (int g = 0; g < NUM_GRPS; g++)
        begin
            grp_free[g] = ~&used_pad[g*csem_pkg::GRP_SIZE +: csem_pkg::GRP_SIZE];
        end
        grp_sel = '0;
        for (int g = NUM_GRPS - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                grp_sel = GRP_W'(g);
            end
        end
    end

    always_comb
    begin
        grp_bits = used_pad[{grp_reg, {csem_pkg::GRP_BITS{1'b0}}} +: csem_pkg::GRP_SIZE];
        bit_sel  = '0;
        for (int b = csem_pkg::GRP_SIZE - 1; b >= 0; b--)
        begin
            if (!grp_bits[b])
            begin
                bit_sel = csem_pkg::GRP_BITS'(b);
            end
        end
        alloc_wide = {grp_reg, bit_sel};
        alloc_slot = alloc_wide[IDX_W-1:0];
        alloc_w32  = 32'(alloc_slot);
    end

    // saturating count arithmetic
    always_comb
    begin
        init_w = 33'(init_reg);
        if (init_w > WIDE_MAX)
        begin
            sat_w = WIDE_MAX;
        end
        else if (init_w < WIDE_MIN)
        begin
            sat_w = WIDE_MIN;
        end
        else
        begin
            sat_w = init_w;
        end
        init_sat = sat_w[COUNT_BITS-1:0];
        cnt_dec  = (rd_count_reg == CNT_MIN) ? rd_count_reg : (rd_count_reg - CNT_ONE);
        cnt_inc  = (rd_count_reg == CNT_MAX) ? rd_count_reg : (rd_count_reg + CNT_ONE);
    end

    // command decode
    always_comb
    begin
        res_load    = 1'b0;
        status_next = csem_pkg::ST_OK;
        slot_next   = idx_reg;
        block_next  = 1'b0;
        wake_next   = 1'b0;
        upd_count   = '0;
        wr_en       = 1'b0;
        wr_addr     = alloc_slot;
        wr_data     = init_sat;
        in_use_next = in_use_reg;
        used_next   = used_reg;

        if (ctl.find_group && sts.table_full)
        begin
            res_load    = 1'b1;
            status_next = csem_pkg::ST_FULL;
            slot_next   = '0;
        end

        if (ctl.find_slot)
        begin
            res_load                = 1'b1;
            wr_en                   = 1'b1;
            slot_next               = alloc_w32[csem_pkg::IDX_FW-1:0];
            upd_count               = init_sat;
            in_use_next[alloc_slot] = 1'b1;
            used_next               = used_reg + USED_W'(1);
        end

        if (ctl.exec)
        begin
            res_load = 1'b1;
            wr_addr  = idx_slot;
            if (!alloc_ok)
            begin
                status_next = csem_pkg::ST_NOT_ALLOC;
            end
            else
            begin
                wr_en = 1'b1;
                unique case (cmd_reg)
                    csem_pkg::CMD_WAIT:
                    begin
                        wr_data    = cnt_dec;
                        upd_count  = cnt_dec;
                        block_next = cnt_dec[COUNT_BITS-1];
                    end
                    csem_pkg::CMD_SIGNAL:
                    begin
                        wr_data   = cnt_inc;
                        upd_count = cnt_inc;
                        wake_next = cnt_inc[COUNT_BITS-1] || (cnt_inc == '0);
                    end
                    // create never reaches exec
                    csem_pkg::CMD_FREE, csem_pkg::CMD_CREATE:
                    begin
                        wr_data               = '0;
                        in_use_next[idx_slot] = 1'b0;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - USED_W'(1);
                        end
                    end
                endcase
            end
        end

        res_wide = 33'(upd_count);
    end

    // count memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        if (ctl.load)
        begin
            rd_count_reg <= count_mem[rd_addr];
        end
    end

    // payload latches
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            idx_reg  <= target_slot;
            init_reg <= initial_count;
        end
        if (ctl.find_group)
        begin
            grp_reg <= grp_sel;
        end
        if (res_load)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            block_reg  <= block_next;
            wake_reg   <= wake_next;
            count_reg  <= res_wide[csem_pkg::COUNT_FW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            used_reg   <= used_next;
            done_reg   <= res_load;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot_out    = slot_reg;
    assign must_block  = block_reg;
    assign wake_one    = wake_reg;
    assign count_after = count_reg;

    `CSEM_ASSERT_NOW(a_used_matches, 1'b1, $countones(in_use_reg) == int'(used_reg), "tally off")
    `CSEM_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe held over two cycles")
    `CSEM_ASSERT_NOW(a_alloc_free, ctl.find_slot, !in_use_reg[alloc_slot], "slot already used")

endmodule

[sim/csem_result_checker.sv]
// Result checker for the counting semaphore table: predicts each command's result and compares.
// Depends on csem_pkg; instantiated beside the DUT by the testbench top.
`timescale 1ns / 1ps

module csem_result_checker
    import csem_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  cmd_t                        command,
    input  logic [IDX_FW-1:0]           target_slot,
    input  logic signed [COUNT_FW-1:0]  initial_count,
    input  logic                        done,
    input  status_t                     status,
    input  logic [IDX_FW-1:0]           slot_out,
    input  logic                        must_block,
    input  logic                        wake_one,
    input  logic signed [COUNT_FW-1:0]  count_after,
    output int                          errors,
    output int                          outstanding
);

    localparam int COUNT_MAX = 2 ** (COUNT_FW - 1) - 1;
    localparam int COUNT_MIN = -COUNT_MAX - 1;

    typedef struct {
        status_t                     status;
        logic [IDX_FW-1:0]           slot;
        logic                        must_block;
        logic                        wake_one;
        logic signed [COUNT_FW-1:0]  count;
    } sem_result_t;

    sem_result_t                 awaited_results[$];
    bit                          slot_taken[NUM_SEMAPHORES];
    logic signed [COUNT_FW-1:0]  slot_count[NUM_SEMAPHORES];
    int                          slots_taken;

    initial
    begin
        errors      = 0;
        outstanding = 0;
        slots_taken = 0;
        foreach (slot_taken[i])
        begin
            slot_taken[i] = 1'b0;
            slot_count[i] = '0;
        end
    end

    // one command against the semaphore table; returns the result it gives
    function automatic sem_result_t apply_command(cmd_t cmd, int idx,
                                                  logic signed [COUNT_FW-1:0] init);
        sem_result_t r;
        int          c;
        r.status     = ST_OK;
        r.slot       = idx[IDX_FW-1:0];
        r.must_block = 1'b0;
        r.wake_one   = 1'b0;
        r.count      = '0;
        if (cmd == CMD_CREATE)
        begin
            r.status = ST_FULL;
            r.slot   = '0;
            if (slots_taken < NUM_SEMAPHORES)
            begin
                for (int i = 0; i < NUM_SEMAPHORES; i++)
                begin
                    if (!slot_taken[i])
                    begin
                        slot_taken[i] = 1'b1;
                        slot_count[i] = init;   // field width equals count width
                        slots_taken++;
                        r.status = ST_OK;
                        r.slot   = i[IDX_FW-1:0];
                        r.count  = init;
                        break;
                    end
                end
            end
        end
        else if (idx >= NUM_SEMAPHORES || !slot_taken[idx])
        begin
            r.status = ST_NOT_ALLOC;
        end
        else
        begin
            c = slot_count[idx];
            case (cmd)
                CMD_WAIT:
                begin
                    if (c > COUNT_MIN)
                        c--;
                    r.must_block = (c < 0);
                end
                CMD_SIGNAL:
                begin
                    if (c < COUNT_MAX)
                        c++;
                    r.wake_one = (c <= 0);
                end
                default:
                begin
                    slot_taken[idx] = 1'b0;
                    c = 0;
                    if (slots_taken > 0)
                        slots_taken--;
                end
            endcase
            slot_count[idx] = c[COUNT_FW-1:0];
            r.count         = c[COUNT_FW-1:0];
        end
        return r;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // results are retired before the beat on the same edge is predicted
    always @(posedge clk)
    begin
        sem_result_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    errors++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    check_field("status", exp_r.status, status);
                    check_field("slot_out", exp_r.slot, slot_out);
                    check_field("must_block", exp_r.must_block, must_block);
                    check_field("wake_one", exp_r.wake_one, wake_one);
                    check_field("count_after", exp_r.count, count_after);
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_command(command, target_slot, initial_count));
            outstanding = awaited_results.size();
        end
    end

endmodule

[sim/testbench.sv]
// Testbench top for the counting semaphore table: clock, reset, command stimulus and verdict.
// Depends on csem_pkg, counting_semaphore_table_top and csem_result_checker.
`timescale 1ns / 1ps

module testbench;
    import csem_pkg::*;

    localparam int NUM_SEMAPHORES = 128;
    localparam int COUNT_BITS     = 16;

    // random part in four phases: fill, work on a full table, drain, churn
    localparam int FILL_BEATS  = 260;
    localparam int FULL_BEATS  = 220;
    localparam int DRAIN_BEATS = 220;
    localparam int CHURN_BEATS = 225;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    cmd_t                        command;
    logic [IDX_FW-1:0]           target_slot;
    logic signed [COUNT_FW-1:0]  initial_count;
    logic                        done;
    status_t                     status;
    logic [IDX_FW-1:0]           slot_out;
    logic                        must_block;
    logic                        wake_one;
    logic signed [COUNT_FW-1:0]  count_after;
    int                          errors;
    int                          outstanding;
    bit                          burst;   // no idling while set

    // 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    counting_semaphore_table_top #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .COUNT_BITS     (COUNT_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .target_slot   (target_slot),
        .initial_count (initial_count),
        .done          (done),
        .status        (status),
        .slot_out      (slot_out),
        .must_block    (must_block),
        .wake_one      (wake_one),
        .count_after   (count_after)
    );

    csem_result_checker #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .target_slot   (target_slot),
        .initial_count (initial_count),
        .done          (done),
        .status        (status),
        .slot_out      (slot_out),
        .must_block    (must_block),
        .wake_one      (wake_one),
        .count_after   (count_after),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    // Drive one command beat from the falling edge and hold it until the
    // rising edge that takes it (start high, busy low). start stays high on
    // return, so a back-to-back beat does not drop it in between.
    task automatic issue(cmd_t cmd, int idx, logic signed [COUNT_FW-1:0] init);
        @(negedge clk);
        start         <= 1'b1;
        command       <= cmd;
        target_slot   <= idx[IDX_FW-1:0];
        initial_count <= init;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // idle cycles with start low
    task automatic idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // hold off until every command issued so far has answered
    task automatic wait_for_results();
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // mostly back-to-back, sometimes a short gap, now and then a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (burst || roll < 6)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // counts cluster at the extremes and around zero, where the flags turn
    function automatic logic signed [COUNT_FW-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return COUNT_FW'(16'sh7FFF - $urandom_range(0, 2));
            3:       return COUNT_FW'(16'sh8000 + $urandom_range(0, 2));
            4, 5, 6: return COUNT_FW'($urandom_range(0, 6) - 3);
            default: return COUNT_FW'($urandom);
        endcase
    endfunction

    // creates fill from slot 0 upwards, so low slots are the likely live ones
    function automatic int pick_index(int span);
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(0, span - 1);
        return $urandom_range(0, NUM_SEMAPHORES - 1);
    endfunction

    // weights in percent for create, wait and signal; free takes the rest
    task automatic random_phase(int beats, int w_create, int w_wait, int w_signal,
                                int span);
        int   roll;
        cmd_t cmd;
        int   gap;
        for (int n = 0; n < beats; n++)
        begin
            if (n % 32 == 0)
                burst = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < w_create)
                cmd = CMD_CREATE;
            else if (roll < w_create + w_wait)
                cmd = CMD_WAIT;
            else if (roll < w_create + w_wait + w_signal)
                cmd = CMD_SIGNAL;
            else
                cmd = CMD_FREE;
            gap = pick_gap();
            if (gap > 0)
                idle(gap);
            issue(cmd, pick_index(span), pick_count());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = CMD_CREATE;
        target_slot   = '0;
        initial_count = '0;
        burst         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle(2);

        // directed: extremes, every command, saturation and the flag edges
        issue(CMD_SIGNAL, 0, 16'sd5);           // nothing allocated yet
        issue(CMD_CREATE, 127, 16'sh7FFF);      // slot 0 at maximum, index ignored
        issue(CMD_CREATE, 0, 16'sh8000);        // slot 1 at minimum
        issue(CMD_CREATE, 64, 16'sd0);          // slot 2
        issue(CMD_CREATE, 3, -16'sd1);          // slot 3
        issue(CMD_SIGNAL, 0, 16'sd0);           // holds at maximum, no wake
        issue(CMD_WAIT, 1, 16'sd0);             // holds at minimum, still blocks
        issue(CMD_WAIT, 2, 16'sd0);             // 0 -> -1, blocks
        issue(CMD_SIGNAL, 3, 16'sd0);           // -1 -> 0, wakes
        issue(CMD_SIGNAL, 3, 16'sd0);           // 0 -> 1, no wake
        issue(CMD_WAIT, 0, 16'sd0);             // maximum down by one, no block
        issue(CMD_FREE, 1, 16'sd0);
        issue(CMD_WAIT, 1, 16'sd0);             // freed slot
        issue(CMD_FREE, 1, 16'sd0);             // double free
        issue(CMD_CREATE, 90, 16'sh1234);       // reuses lowest free, slot 1
        issue(CMD_WAIT, 127, 16'sd0);           // top index, never allocated
        issue(CMD_SIGNAL, 2, 16'sd0);           // -1 -> 0, wakes
        issue(CMD_FREE, 0, 16'sd0);
        issue(CMD_FREE, 2, 16'sd0);
        issue(CMD_FREE, 3, 16'sd0);
        issue(CMD_FREE, 1, 16'sd0);
        idle(1);

        // sender holds off until the table has answered everything
        wait_for_results();

        random_phase(FILL_BEATS, 70, 12, 13, NUM_SEMAPHORES);
        idle(1);
        wait_for_results();
        random_phase(FULL_BEATS, 10, 40, 40, NUM_SEMAPHORES);
        random_phase(DRAIN_BEATS, 10, 22, 23, NUM_SEMAPHORES);
        random_phase(CHURN_BEATS, 25, 25, 25, 16);
        idle(1);

        wait_for_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // far beyond the slowest legal run (about 950 beats, each after the longest gap)
    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule
